FILE: sv/byte_level_unicode_remap_codec_top_assert.svh
// Assertion macros for the byte-level remap codec checker.
`ifndef BYTE_LEVEL_UNICODE_REMAP_CODEC_TOP_ASSERT_SVH
`define BYTE_LEVEL_UNICODE_REMAP_CODEC_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BLURC_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("blurc assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define BLURC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("blurc assertion failed");

`endif

FILE: sv/blurc_pkg.sv
// Shared types, constants and mapping functions for the byte-level remap codec.
`default_nettype none
package blurc_pkg;

  // direction register codes
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] QMARK = 8'd63;

  // job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_piece;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       unmapped;
    logic       last_result;
  } out_t;

  // one or two results caused by one input beat
  typedef struct packed {
    logic two;
    out_t res0;
    out_t res1;
  } job_t;

  function automatic logic is_base(input logic [7:0] b);
    return b inside {[8'd33:8'd126], [8'd161:8'd172], [8'd174:8'd255]};
  endfunction

  // raw byte -> remapped codepoint (33..323)
  function automatic logic [8:0] raw_to_codepoint(input logic [7:0] b);
    logic [8:0] cp;
    if (is_base(b)) begin
      cp = {1'b0, b};
    end else if (b <= 8'd32) begin
      cp = 9'd256 + {1'b0, b};
    end else if (b == 8'd127) begin
      cp = 9'd289;
    end else if (b >= 8'd128 && b <= 8'd160) begin
      cp = {1'b0, b} + 9'd162;
    end else begin
      cp = 9'd323;
    end
    return cp;
  endfunction

  // codepoint -> result beat; '?' and unmapped when no byte owns it
  function automatic out_t put_cp(input logic [15:0] cp, input logic last);
    out_t       r;
    logic [8:0] n;
    n = cp[8:0] - 9'd256;
    r.last_result = last;
    r.unmapped    = 1'b0;
    r.out_byte    = QMARK;
    if (cp[15:9] != 7'd0) begin
      r.unmapped = 1'b1;
    end else if (!cp[8]) begin
      if (is_base(cp[7:0])) r.out_byte = cp[7:0];
      else r.unmapped = 1'b1;
    end else if (n <= 9'd32) begin
      r.out_byte = n[7:0];
    end else if (n == 9'd33) begin
      r.out_byte = 8'd127;
    end else if (n <= 9'd66) begin
      r.out_byte = n[7:0] + 8'd94;
    end else if (n == 9'd67) begin
      r.out_byte = 8'd173;
    end else begin
      r.unmapped = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/blurc_front.sv
// Front end: accepts input beats, tracks UTF-8 pending bytes, builds result jobs.
`default_nettype none
module blurc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              push,
  input  wire blurc_pkg::in_t    item,
  output logic                   full,
  output logic                   q_push,
  output blurc_pkg::job_t        q_data,
  input  wire logic              q_full
);

  logic       direction;
  logic [1:0] pending_count, pending_count_next;
  logic [7:0] pending_lead, pending_lead_next;
  logic [7:0] pending_second, pending_second_next;
  logic       accept, has_res;
  logic [8:0] enc_cp;
  logic [7:0] b;
  logic       last;

  assign b      = item.data_byte;
  assign last   = item.last_of_piece;
  assign full   = q_full;
  assign accept = push && !q_full;
  assign q_push = accept && has_res;
  assign enc_cp = blurc_pkg::raw_to_codepoint(b);

  // classify the beat and form its results
  always_comb begin
    q_data              = '0;
    has_res             = 1'b0;
    pending_count_next  = pending_count;
    pending_lead_next   = pending_lead;
    pending_second_next = pending_second;
    if (direction == blurc_pkg::DIR_ENCODE) begin
      has_res = 1'b1;
      if (enc_cp < 9'h080) begin
        q_data.res0 = '{out_byte: enc_cp[7:0], unmapped: 1'b0, last_result: 1'b1};
      end else begin
        q_data.two  = 1'b1;
        q_data.res0 = '{out_byte: 8'hC0 | {5'd0, enc_cp[8:6]}, unmapped: 1'b0,
                        last_result: 1'b0};
        q_data.res1 = '{out_byte: 8'h80 | {2'd0, enc_cp[5:0]}, unmapped: 1'b0,
                        last_result: 1'b1};
      end
    end else begin
      case (pending_count)
        2'd0: begin
          if ((b[7:5] == 3'b110 || b[7:4] == 4'b1110) && !last) begin
            pending_lead_next  = b;
            pending_count_next = 2'd1;
          end else begin
            has_res     = 1'b1;
            q_data.res0 = blurc_pkg::put_cp({8'd0, b}, 1'b1);
          end
        end
        2'd1: begin
          if (pending_lead[7:5] == 3'b110) begin
            has_res            = 1'b1;
            pending_count_next = 2'd0;
            q_data.res0 = blurc_pkg::put_cp({5'd0, pending_lead[4:0], b[5:0]}, 1'b1);
          end else if (last) begin
            // three-byte sequence cut short: both bytes stand alone
            has_res            = 1'b1;
            pending_count_next = 2'd0;
            q_data.two  = 1'b1;
            q_data.res0 = blurc_pkg::put_cp({8'd0, pending_lead}, 1'b0);
            q_data.res1 = blurc_pkg::put_cp({8'd0, b}, 1'b1);
          end else begin
            pending_second_next = b;
            pending_count_next  = 2'd2;
          end
        end
        2'd2: begin
          has_res            = 1'b1;
          pending_count_next = 2'd0;
          q_data.res0 = blurc_pkg::put_cp(
            {pending_lead[3:0], pending_second[5:0], b[5:0]}, 1'b1);
        end
        default: begin
          pending_count_next = 2'd0;
        end
      endcase
    end
  end

  // control state: direction and pending count
  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= blurc_pkg::DIR_ENCODE;
      pending_count <= 2'd0;
    end else if (cfg_we) begin
      direction     <= cfg_wdata;
      pending_count <= 2'd0;
    end else if (accept && direction == blurc_pkg::DIR_DECODE) begin
      pending_count <= pending_count_next;
    end
  end

  // held bytes, only meaningful under pending_count
  always_ff @(posedge clk) begin
    if (accept) begin
      pending_lead   <= pending_lead_next;
      pending_second <= pending_second_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/blurc_fifo.sv
// Short job queue between front and back.
`default_nettype none
module blurc_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire blurc_pkg::job_t   wr_data,
  output logic                   full,
  input  wire logic              rd,
  output blurc_pkg::job_t        rd_data,
  output logic                   empty
);

  blurc_pkg::job_t                   mem [blurc_pkg::QDEPTH];
  logic [blurc_pkg::QPTR_W-1:0]      wptr, rptr;
  logic [blurc_pkg::QCNT_W-1:0]      count;
  logic                              do_wr, do_rd;

  assign full    = count == blurc_pkg::QCNT_W'(blurc_pkg::QDEPTH);
  assign empty   = count == '0;
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) wptr <= wptr + 1'b1;
      if (do_rd) rptr <= rptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wptr] <= wr_data;
  end

endmodule
`default_nettype wire

FILE: sv/blurc_back.sv
// Back end: takes queued jobs, gives one result beat a cycle while pop is high.
`default_nettype none
module blurc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  input  wire blurc_pkg::job_t   q_data,
  output logic                   q_pop,
  input  wire logic              pop,
  output logic                   empty,
  output blurc_pkg::out_t        result
);

  blurc_pkg::job_t cur;
  logic            cur_valid;
  logic            idx;
  logic            take_beat, job_done;

  assign empty     = !cur_valid;
  assign result    = idx ? cur.res1 : cur.res0;
  assign take_beat = pop && cur_valid;
  assign job_done  = !(cur.two && !idx);
  assign q_pop     = (!cur_valid || (take_beat && job_done)) && !q_empty;

  // current job and beat index
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (q_pop) begin
      cur_valid <= 1'b1;
      idx       <= 1'b0;
    end else if (take_beat) begin
      if (job_done) cur_valid <= 1'b0;
      else idx <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

endmodule
`default_nettype wire

FILE: sv/byte_level_unicode_remap_codec_top.sv
// Top level of the byte-level remap codec.
//
// Input channel: push/full with item (data_byte, last_of_piece); a beat is taken
// at a clock edge with push high and full low. Result channel: empty/pop with
// result (out_byte, unmapped, last_result); the oldest result shows while empty
// is low and leaves at an edge with pop high.
// cfg_we/cfg_wdata write direction (0 encode, 1 decode) and clear any held
// UTF-8 bytes; write only while the block is idle.
// A result passes through the job queue and then the back end's job register
// before it shows. One input beat is taken per cycle while each makes at most
// one result and pop stays high; encoded bytes needing two UTF-8 bytes each go
// slower, bound by the one result beat per cycle of the back end. Decode bytes
// that are only held make no result.
// A two-entry job queue lies between the front end and the back end, so the
// front keeps taking input while a result waits; when pop stays low the queue
// fills and full rises.
// Reset (rst, synchronous): direction encode, nothing held, queue and result
// port empty.
`default_nettype none
module byte_level_unicode_remap_codec_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_wdata,
  input  wire logic              push,
  output logic                   full,
  input  wire blurc_pkg::in_t    item,
  input  wire logic              pop,
  output logic                   empty,
  output blurc_pkg::out_t        result
);

  blurc_pkg::job_t f_data, b_data;
  logic            f_push, q_full, q_empty, q_pop;

  blurc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .item      (item),
    .full      (full),
    .q_push    (f_push),
    .q_data    (f_data),
    .q_full    (q_full)
  );

  blurc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (f_push),
    .wr_data (f_data),
    .full    (q_full),
    .rd      (q_pop),
    .rd_data (b_data),
    .empty   (q_empty)
  );

  blurc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (b_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule
`default_nettype wire

FILE: sv/blurc_checker.sv
// Port-level checker for the byte-level remap codec, bound to the top level.
`default_nettype none
`include "byte_level_unicode_remap_codec_top_assert.svh"
module blurc_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            pop,
  input wire logic            empty,
  input wire blurc_pkg::out_t result
);

  // a waiting result beat holds until popped
  `BLURC_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result))

  // a substituted byte is always '?'
  `BLURC_ASSERT(a_qmark, !empty && result.unmapped, result.out_byte == blurc_pkg::QMARK)

  // the second beat of a pair follows right after the first
  `BLURC_ASSERT_NEXT(a_pair, !empty && pop && !result.last_result, !empty)

  // nothing waits right after reset
  `BLURC_ASSERT(a_rst_empty, $fell(rst), empty)

endmodule

bind byte_level_unicode_remap_codec_top blurc_checker u_blurc_checker (
  .clk    (clk),
  .rst    (rst),
  .pop    (pop),
  .empty  (empty),
  .result (result)
);
`default_nettype wire
